>>> rtl/core/cwt_pkg.sv
// Package for the counter widening table: field widths, reset values,
// command codes and the controller-to-datapath command and status structs.
// Depends on nothing; every other file of the block imports it.
package cwt_pkg;

  localparam int unsigned MAX_PORTS_DEF    = 32;
  localparam int unsigned MAX_COUNTERS_DEF = 64;

  localparam int unsigned LOW_BITS = 16;
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned HIGH_W   = WORD_W - LOW_BITS;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned PORT_W  = 5;
  localparam int unsigned WADDR_W = 4;
  localparam int unsigned MASK_W  = 64;
  localparam int unsigned BYTES_W = 32;
  localparam int unsigned CIDX_W  = 6;
  localparam int unsigned PCNT_W  = 6;
  localparam int unsigned CCNT_W  = 7;

  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  localparam logic [PCNT_W-1:0] PORTS_RST    = 6'd18;
  localparam logic [CCNT_W-1:0] COUNTERS_RST = 7'd39;

  // Register select is paddr[2].
  localparam logic REG_PORTS    = 1'b0;
  localparam logic REG_COUNTERS = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_OVERFLOW = 2'd0,
    CMD_READ     = 2'd1,
    CMD_ZERO     = 2'd2
  } cmd_e;

  typedef struct packed {
    logic              capture;
    logic              mem_rd;
    logic              ovf_rd;
    logic              wr_zero;
    logic              wr_clear;
    logic              load_out;
    logic              last;
    logic [CIDX_W-1:0] cnt_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/core/cwt_in_if.sv
// Input channel of the counter widening table: valid, ready and one command beat.
// Depends on cwt_pkg for the field widths.
interface cwt_in_if import cwt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [PORT_W-1:0]  port;
  logic [WADDR_W-1:0] word_address;
  logic [MASK_W-1:0]  overflow_mask;
  logic [BYTES_W-1:0] low_word;
  logic [BYTES_W-1:0] high_word;

  modport source (
    output valid, cmd, port, word_address, overflow_mask, low_word, high_word,
    input  ready
  );
  modport sink (
    input  valid, cmd, port, word_address, overflow_mask, low_word, high_word,
    output ready
  );
endinterface

>>> rtl/core/cwt_out_if.sv
// Output channel of the counter widening table: valid, ready and one counter beat.
// Depends on cwt_pkg for the field widths.
interface cwt_out_if import cwt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] counter_index;
  logic [WORD_W-1:0] counter_value;
  logic              last;

  modport source (
    output valid, counter_index, counter_value, last,
    input  ready
  );
  modport sink (
    input  valid, counter_index, counter_value, last,
    output ready
  );
endinterface

>>> rtl/core/cwt_cfg.sv
// APB register file of the counter widening table: port count and counter count,
// clamped to the configured maximum. Depends on cwt_pkg.
module cwt_cfg import cwt_pkg::*; #(
  parameter int unsigned MAX_PORTS    = MAX_PORTS_DEF,
  parameter int unsigned MAX_COUNTERS = MAX_COUNTERS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [PCNT_W-1:0] eff_ports_o,
  output logic [CCNT_W-1:0] eff_counters_o
);

  logic [PCNT_W-1:0] ports_q;
  logic [CCNT_W-1:0] counters_q;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ports_q    <= PORTS_RST;
      counters_q <= COUNTERS_RST;
    end else if (wr_en) begin
      if (paddr[2] == REG_COUNTERS) begin
        counters_q <= pwdata[CCNT_W-1:0];
      end else begin
        ports_q <= pwdata[PCNT_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_COUNTERS) ? APB_DW'(counters_q) : APB_DW'(ports_q);

  assign eff_ports_o    = (ports_q > PCNT_W'(MAX_PORTS)) ? PCNT_W'(MAX_PORTS) : ports_q;
  assign eff_counters_o = (counters_q > CCNT_W'(MAX_COUNTERS)) ?
                          CCNT_W'(MAX_COUNTERS) : counters_q;

endmodule

>>> rtl/core/cwt_ctrl.sv
// Controller of the counter widening table: accepts commands, walks counters
// and sequences the table memory and output register. Depends on cwt_pkg.
module cwt_ctrl import cwt_pkg::*; #(
  parameter int unsigned MAX_PORTS    = MAX_PORTS_DEF,
  parameter int unsigned MAX_COUNTERS = MAX_COUNTERS_DEF,
  parameter int unsigned DEPTH        = MAX_PORTS_DEF * MAX_COUNTERS_DEF,
  parameter int unsigned AW           = 11
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CMD_W-1:0]   in_cmd_i,
  input  logic [PORT_W-1:0]  in_port_i,
  input  logic [WADDR_W-1:0] in_waddr_i,
  input  logic [PCNT_W-1:0]  eff_ports_i,
  input  logic [CCNT_W-1:0]  eff_counters_i,
  input  dp_status_t         dp_status_i,
  output dp_cmd_t            dp_cmd_o,
  output logic [AW-1:0]      mem_addr_o
);

  localparam int unsigned CIW = $clog2(MAX_COUNTERS);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_OVF,
    ST_RD_ISSUE,
    ST_RD_LOAD,
    ST_ZERO
  } state_e;

  state_e            state_q;
  logic [CIDX_W-1:0] cur_q;
  logic [PORT_W-1:0] port_q;
  logic [AW-1:0]     clr_q;

  logic              accept;
  logic              port_ok;
  logic [CIDX_W-1:0] first_idx;
  logic              grp_ok;
  logic [CIDX_W:0]   cur_inc;
  logic              cnt_end;
  logic              run_end;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign port_ok    = {1'b0, in_port_i} < eff_ports_i;
  assign first_idx  = {in_waddr_i, 2'b00};
  assign grp_ok     = {1'b0, first_idx} < eff_counters_i;
  assign cur_inc    = {1'b0, cur_q} + 7'd1;
  assign cnt_end    = cur_inc >= eff_counters_i;
  // A read or zero run covers one group of four and stops at the count in use.
  assign run_end    = (cur_q[1:0] == 2'd3) || cnt_end;

  assign mem_addr_o = (state_q == ST_CLEAR) ? clr_q : AW'({port_q, cur_q[CIW-1:0]});

  always_comb begin
    dp_cmd_o          = '0;
    dp_cmd_o.capture  = accept;
    dp_cmd_o.ovf_rd   = (state_q == ST_OVF);
    dp_cmd_o.mem_rd   = (state_q == ST_RD_ISSUE);
    dp_cmd_o.wr_zero  = (state_q == ST_ZERO);
    dp_cmd_o.wr_clear = (state_q == ST_CLEAR);
    dp_cmd_o.load_out = (state_q == ST_RD_LOAD) && dp_status_i.out_free;
    dp_cmd_o.last     = run_end;
    dp_cmd_o.cnt_idx  = cur_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cur_q   <= '0;
      port_q  <= '0;
      clr_q   <= '0;
    end else begin
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept && port_ok) begin
            port_q <= in_port_i;
            unique case (in_cmd_i)
              CMD_OVERFLOW: begin
                if (eff_counters_i != '0) begin
                  cur_q   <= '0;
                  state_q <= ST_OVF;
                end
              end
              CMD_READ: begin
                if (grp_ok) begin
                  cur_q   <= first_idx;
                  state_q <= ST_RD_ISSUE;
                end
              end
              CMD_ZERO: begin
                if (grp_ok) begin
                  cur_q   <= first_idx;
                  state_q <= ST_ZERO;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_OVF: begin
          if (cnt_end) begin
            state_q <= ST_IDLE;
          end else begin
            cur_q <= cur_inc[CIDX_W-1:0];
          end
        end
        ST_RD_ISSUE: begin
          state_q <= ST_RD_LOAD;
        end
        ST_RD_LOAD: begin
          if (dp_status_i.out_free) begin
            if (run_end) begin
              state_q <= ST_IDLE;
            end else begin
              cur_q   <= cur_inc[CIDX_W-1:0];
              state_q <= ST_RD_ISSUE;
            end
          end
        end
        ST_ZERO: begin
          if (run_end) begin
            state_q <= ST_IDLE;
          end else begin
            cur_q <= cur_inc[CIDX_W-1:0];
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/cwt_dp.sv
// Datapath of the counter widening table: table memory of high parts and zero
// biases, increment and bias arithmetic, output register. Depends on cwt_pkg.
module cwt_dp import cwt_pkg::*; #(
  parameter int unsigned DEPTH = MAX_PORTS_DEF * MAX_COUNTERS_DEF,
  parameter int unsigned AW    = 11
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            dp_cmd_i,
  input  logic [AW-1:0]      mem_addr_i,
  input  logic [MASK_W-1:0]  in_mask_i,
  input  logic [BYTES_W-1:0] in_low_i,
  input  logic [BYTES_W-1:0] in_high_i,
  output dp_status_t         dp_status_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CIDX_W-1:0]  out_index_o,
  output logic [WORD_W-1:0]  out_value_o,
  output logic               out_last_o
);

  // Each entry holds the high part above the zero bias.
  logic [WORD_W-1:0] mem [DEPTH];

  logic [MASK_W-1:0]   mask_q;
  logic [BYTES_W-1:0]  low_q;
  logic [BYTES_W-1:0]  high_q;
  logic [WORD_W-1:0]   rdata_q;
  logic [AW-1:0]       inc_addr_q;
  logic                inc_pend_q;
  logic                out_valid_q;
  logic [CIDX_W-1:0]   out_index_q;
  logic [WORD_W-1:0]   out_value_q;
  logic                out_last_q;

  logic [1:0]          lane;
  logic [LOW_BITS-1:0] raw;
  logic                ovf_hit;
  logic                rd_en;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [WORD_W-1:0]   wr_data;
  logic [WORD_W-1:0]   value;

  assign lane    = dp_cmd_i.cnt_idx[1:0];
  assign raw     = {high_q[{lane, 3'b000} +: 8], low_q[{lane, 3'b000} +: 8]};
  assign ovf_hit = dp_cmd_i.ovf_rd && mask_q[dp_cmd_i.cnt_idx];
  assign rd_en   = dp_cmd_i.mem_rd || ovf_hit;

  // The increment write lands in the cycle after its read; the controller never
  // touches the same entry in that cycle.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = mem_addr_i;
    wr_data = '0;
    priority if (inc_pend_q) begin
      wr_en   = 1'b1;
      wr_addr = inc_addr_q;
      wr_data = {rdata_q[WORD_W-1:LOW_BITS] + HIGH_W'(1), rdata_q[LOW_BITS-1:0]};
    end else if (dp_cmd_i.wr_zero) begin
      wr_en   = 1'b1;
      wr_data = {HIGH_W'(0), raw};
    end else if (dp_cmd_i.wr_clear) begin
      wr_en   = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q    <= mem[mem_addr_i];
      inc_addr_q <= mem_addr_i;
    end
    if (dp_cmd_i.capture) begin
      mask_q <= in_mask_i;
      low_q  <= in_low_i;
      high_q <= in_high_i;
    end
  end

  assign value = {rdata_q[WORD_W-1:LOW_BITS], raw} - WORD_W'(rdata_q[LOW_BITS-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      inc_pend_q <= ovf_hit;
      if (dp_cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.load_out) begin
      out_index_q <= dp_cmd_i.cnt_idx;
      out_value_q <= value;
      out_last_q  <= dp_cmd_i.last;
    end
  end

  assign dp_status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o          = out_valid_q;
  assign out_index_o          = out_index_q;
  assign out_value_o          = out_value_q;
  assign out_last_o           = out_last_q;

endmodule

>>> rtl/core/counter_widening_table.sv
// Top level of the counter widening table: APB registers, controller and datapath.
// Depends on cwt_pkg, cwt_in_if, cwt_out_if, cwt_cfg, cwt_ctrl and cwt_dp.
//
// The block widens 16-bit hardware statistics counters to 64 bits. Each beat on
// in_i is one command for one port: an overflow command adds one to the stored
// high part of every flagged counter, a read command returns up to four widened
// counter values on out_o (the final one of the run marked by last), and a zero
// command clears the high parts of a group of four and keeps the raw values as
// the new zero bias, which is subtracted on every later read.
// Sequencing: an overflow command walks the counters in use, one per cycle
// through the table memory's single read port. A read command handles one counter
// at a time (memory read, then load of the output register) and issues the next
// counter's read only once the current one is loaded. A zero command writes one
// counter per cycle. After reset the block clears the whole table, one entry per
// cycle, MAX_PORTS * 2**ceil(log2(MAX_COUNTERS)) entries (2048 at the defaults);
// in_i is not ready meanwhile, while the APB registers can already be written.
// A stalled sink holds the current result in the output register; the read run
// waits for it, and in_i accepts the next command once the run has loaded its
// final beat.
module counter_widening_table import cwt_pkg::*; #(
  parameter int unsigned MAX_PORTS    = MAX_PORTS_DEF,
  parameter int unsigned MAX_COUNTERS = MAX_COUNTERS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  cwt_in_if.sink            in_i,
  cwt_out_if.source         out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  // Each port owns a row of 2**CIW entries, so an entry address is {port, index}.
  localparam int unsigned CIW   = $clog2(MAX_COUNTERS);
  localparam int unsigned DEPTH = MAX_PORTS << CIW;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic [PCNT_W-1:0] eff_ports;
  logic [CCNT_W-1:0] eff_counters;
  dp_cmd_t           dp_cmd;
  dp_status_t        dp_status;
  logic [AW-1:0]     mem_addr;

  cwt_cfg #(
    .MAX_PORTS    (MAX_PORTS),
    .MAX_COUNTERS (MAX_COUNTERS)
  ) u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .eff_ports_o    (eff_ports),
    .eff_counters_o (eff_counters)
  );

  cwt_ctrl #(
    .MAX_PORTS    (MAX_PORTS),
    .MAX_COUNTERS (MAX_COUNTERS),
    .DEPTH        (DEPTH),
    .AW           (AW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_i.valid),
    .in_ready_o     (in_i.ready),
    .in_cmd_i       (in_i.cmd),
    .in_port_i      (in_i.port),
    .in_waddr_i     (in_i.word_address),
    .eff_ports_i    (eff_ports),
    .eff_counters_i (eff_counters),
    .dp_status_i    (dp_status),
    .dp_cmd_o       (dp_cmd),
    .mem_addr_o     (mem_addr)
  );

  cwt_dp #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dp_cmd_i    (dp_cmd),
    .mem_addr_i  (mem_addr),
    .in_mask_i   (in_i.overflow_mask),
    .in_low_i    (in_i.low_word),
    .in_high_i   (in_i.high_word),
    .dp_status_o (dp_status),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_index_o (out_o.counter_index),
    .out_value_o (out_o.counter_value),
    .out_last_o  (out_o.last)
  );

endmodule

>>> rtl/core/cwt_checker.sv
// Port-level checks for the counter widening table, bound to its top level.
// Depends on cwt_pkg and counter_widening_table.
module cwt_checker import cwt_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CIDX_W-1:0] out_index,
  input logic [WORD_W-1:0] out_value,
  input logic              out_last
);

  // The table clear starts at reset, so no command is taken right after it.
  a_no_accept_after_reset: assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !in_ready)
    else $error("input ready right after reset");

  // While a read run still has beats to deliver, no new command is taken.
  a_run_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && !out_last |-> !in_ready)
    else $error("input ready in the middle of a read run");

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=>
      $stable(out_index) && $stable(out_value) && $stable(out_last))
    else $error("result changed while stalled");

endmodule

bind counter_widening_table cwt_checker u_cwt_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_index (out_o.counter_index),
  .out_value (out_o.counter_value),
  .out_last  (out_o.last)
);
